@@ design/buh_pkg.sv @@
// Shared types, codes and defaults for the bounded undo/redo history unit.
`timescale 1ns / 1ps

package buh_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int COORD_BITS_DEF = 8;
    localparam int LIMIT_W        = 7;
    localparam int FIELD_W        = 8;
    localparam int COUNT_W        = 7;
    localparam int FUNC_W         = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNDO  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REDO  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stack_cmd;

endpackage

@@ design/bounded_undo_redo_history_unit.sv @@
// A result item is registered and is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle; input ready drops only while a result waits.
// Both stacks are chains of cells shifting one step per push or pop, so the
// stack top is always in cell 0.
// Reset (synchronous, active low) empties both stacks, clears the limit to zero
// (full depth) and drops the output valid; cell contents are not reset.
`timescale 1ns / 1ps

module bounded_undo_redo_history_unit #(
    parameter int DEPTH      = buh_pkg::DEPTH_DEF,
    parameter int COORD_BITS = buh_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [buh_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [buh_pkg::FUNC_W-1:0]  i_func,
    input  logic [buh_pkg::FIELD_W-1:0] i_src_col,
    input  logic [buh_pkg::FIELD_W-1:0] i_src_row,
    input  logic [buh_pkg::FIELD_W-1:0] i_dst_col,
    input  logic [buh_pkg::FIELD_W-1:0] i_dst_row,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_move_valid,
    output logic [buh_pkg::FIELD_W-1:0] o_out_src_col,
    output logic [buh_pkg::FIELD_W-1:0] o_out_src_row,
    output logic [buh_pkg::FIELD_W-1:0] o_out_dst_col,
    output logic [buh_pkg::FIELD_W-1:0] o_out_dst_row,
    output logic [buh_pkg::COUNT_W-1:0] o_undo_count,
    output logic [buh_pkg::COUNT_W-1:0] o_redo_count
);

    localparam int CB = COORD_BITS;
    localparam int MW = 4 * CB;
    localparam int CW = $clog2(DEPTH + 1);
    // Width wide enough for both the limit register and the depth.
    localparam int LW = (CW > buh_pkg::LIMIT_W) ? CW : buh_pkg::LIMIT_W;

    logic [buh_pkg::LIMIT_W-1:0] r_limit;
    logic [LW-1:0]               w_lim_ext;
    logic [CW-1:0]               w_lim;

    logic                w_accept;
    buh_pkg::t_stack_cmd w_undo_cmd;
    buh_pkg::t_stack_cmd w_redo_cmd;
    logic [MW-1:0]       w_in_move;
    logic [MW-1:0]       w_undo_push;
    logic [MW-1:0]       w_undo_top;
    logic [MW-1:0]       w_redo_top;
    logic [CW-1:0]       w_undo_fill;
    logic [CW-1:0]       w_redo_fill;
    logic [CW-1:0]       w_undo_nfill;
    logic [CW-1:0]       w_redo_nfill;

    logic [MW-1:0] w_ret_move;
    logic          w_ret_valid;

    logic                        r_out_valid;
    logic                        r_move_valid;
    logic [CB-1:0]               r_src_col;
    logic [CB-1:0]               r_src_row;
    logic [CB-1:0]               r_dst_col;
    logic [CB-1:0]               r_dst_row;
    logic [buh_pkg::COUNT_W-1:0] r_undo_count;
    logic [buh_pkg::COUNT_W-1:0] r_redo_count;
    logic [LW-1:0]               w_undo_wide;
    logic [LW-1:0]               w_redo_wide;

    // Limit register: zero or anything past the depth means the full depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign w_lim_ext = (r_limit == '0 || LW'(r_limit) > LW'(DEPTH)) ? LW'(DEPTH)
                                                                      : LW'(r_limit);
    assign w_lim     = CW'(w_lim_ext);

    // Take a new item whenever the result register is free or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Pack the move: source column in the low bits, destination row on top.
    assign w_in_move = {CB'(i_dst_row), CB'(i_dst_col),
                        CB'(i_src_row), CB'(i_src_col)};

    // Decode the operation into push, pop and clear for each stack.
    always_comb begin
        w_undo_cmd  = '0;
        w_redo_cmd  = '0;
        w_ret_valid = 1'b0;
        w_ret_move  = w_undo_top;
        if (w_accept) begin
            unique case (i_func)
                buh_pkg::FUNC_PUSH: begin
                    // Store on undo and forget the redo history.
                    w_undo_cmd.push  = 1'b1;
                    w_redo_cmd.clear = 1'b1;
                end
                buh_pkg::FUNC_UNDO: begin
                    if (w_undo_fill != '0) begin
                        w_undo_cmd.pop  = 1'b1;
                        w_redo_cmd.push = 1'b1;
                        w_ret_valid     = 1'b1;
                        w_ret_move      = w_undo_top;
                    end
                end
                buh_pkg::FUNC_REDO: begin
                    if (w_redo_fill != '0) begin
                        w_redo_cmd.pop  = 1'b1;
                        w_undo_cmd.push = 1'b1;
                        w_ret_valid     = 1'b1;
                        w_ret_move      = w_redo_top;
                    end
                end
                buh_pkg::FUNC_CLEAR: begin
                    w_undo_cmd.clear = 1'b1;
                    w_redo_cmd.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Undo takes a fresh move on push and the redo top on redo.
    assign w_undo_push = (i_func == buh_pkg::FUNC_PUSH) ? w_in_move : w_redo_top;

    buh_stack #(.DEPTH(DEPTH), .W(MW), .CW(CW)) u_undo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_undo_cmd),
        .i_push_data(w_undo_push),
        .i_lim      (w_lim),
        .o_top      (w_undo_top),
        .o_fill     (w_undo_fill),
        .o_next_fill(w_undo_nfill)
    );

    buh_stack #(.DEPTH(DEPTH), .W(MW), .CW(CW)) u_redo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_redo_cmd),
        .i_push_data(w_undo_top),
        .i_lim      (w_lim),
        .o_top      (w_redo_top),
        .o_fill     (w_redo_fill),
        .o_next_fill(w_redo_nfill)
    );

    assign w_undo_wide = LW'(w_undo_nfill);
    assign w_redo_wide = LW'(w_redo_nfill);

    // Result register: hold until taken, load on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_move_valid <= w_ret_valid;
            r_undo_count <= w_undo_wide[buh_pkg::COUNT_W-1:0];
            r_redo_count <= w_redo_wide[buh_pkg::COUNT_W-1:0];
            if (!w_ret_valid) begin
                // No move returned: drive the move fields to zero.
                r_src_col <= '0;
                r_src_row <= '0;
                r_dst_col <= '0;
                r_dst_row <= '0;
            end else if (i_func == buh_pkg::FUNC_UNDO) begin
                // Undo returns the move reversed.
                r_src_col <= w_ret_move[2*CB +: CB];
                r_src_row <= w_ret_move[3*CB +: CB];
                r_dst_col <= w_ret_move[0    +: CB];
                r_dst_row <= w_ret_move[CB   +: CB];
            end else begin
                r_src_col <= w_ret_move[0    +: CB];
                r_src_row <= w_ret_move[CB   +: CB];
                r_dst_col <= w_ret_move[2*CB +: CB];
                r_dst_row <= w_ret_move[3*CB +: CB];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_move_valid  = r_move_valid;
    assign o_out_src_col = buh_pkg::FIELD_W'(r_src_col);
    assign o_out_src_row = buh_pkg::FIELD_W'(r_src_row);
    assign o_out_dst_col = buh_pkg::FIELD_W'(r_dst_col);
    assign o_out_dst_row = buh_pkg::FIELD_W'(r_dst_row);
    assign o_undo_count  = r_undo_count;
    assign o_redo_count  = r_redo_count;

endmodule

@@ design/buh_cell.sv @@
// One stack cell: holds a move and shifts it toward a neighbor on push or pop.
`timescale 1ns / 1ps

module buh_cell #(
    parameter int W = 4 * buh_pkg::COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_push,
    input  logic         i_pop,
    input  logic [W-1:0] i_from_prev,
    input  logic [W-1:0] i_from_next,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_push) begin
            n_data = i_from_prev;
        end else if (i_pop) begin
            n_data = i_from_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ design/buh_stack.sv @@
// Bounded stack: a chain of cells with the newest entry in cell 0 and a fill count.
`timescale 1ns / 1ps

module buh_stack #(
    parameter int DEPTH = buh_pkg::DEPTH_DEF,
    parameter int W     = 4 * buh_pkg::COORD_BITS_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  buh_pkg::t_stack_cmd i_cmd,
    input  logic [W-1:0]       i_push_data,
    input  logic [CW-1:0]      i_lim,
    output logic [W-1:0]       o_top,
    output logic [CW-1:0]      o_fill,
    output logic [CW-1:0]      o_next_fill
);

    logic [W-1:0]  w_data [DEPTH];
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic [CW-1:0] w_base;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [W-1:0] w_prev;
        logic [W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = i_push_data;
        end else begin : g_mid
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_data[g+1];
        end
        buh_cell #(.W(W)) u_cell (
            .i_clk      (i_clk),
            .i_push     (i_cmd.push),
            .i_pop      (i_cmd.pop),
            .i_from_prev(w_prev),
            .i_from_next(w_next),
            .o_data     (w_data[g])
        );
    end

    // Clamp to the current limit every cycle so a limit write trims the count.
    always_comb begin
        w_base = (r_fill > i_lim) ? i_lim : r_fill;
        n_fill = w_base;
        if (i_cmd.clear) begin
            n_fill = '0;
        end else if (i_cmd.push) begin
            n_fill = (w_base < i_lim) ? w_base + CW'(1) : i_lim;
        end else if (i_cmd.pop) begin
            n_fill = w_base - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_top       = w_data[0];
    assign o_fill      = r_fill;
    assign o_next_fill = n_fill;

endmodule

@@ design/buh_checker.sv @@
// Port-level checker for the bounded undo/redo history unit, with its bind.
`timescale 1ns / 1ps

module buh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [buh_pkg::LIMIT_W-1:0] i_cfg_data,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [buh_pkg::FUNC_W-1:0]  i_func,
    input logic [buh_pkg::FIELD_W-1:0] i_src_col,
    input logic [buh_pkg::FIELD_W-1:0] i_src_row,
    input logic [buh_pkg::FIELD_W-1:0] i_dst_col,
    input logic [buh_pkg::FIELD_W-1:0] i_dst_row,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_move_valid,
    input logic [buh_pkg::FIELD_W-1:0] o_out_src_col,
    input logic [buh_pkg::FIELD_W-1:0] o_out_src_row,
    input logic [buh_pkg::FIELD_W-1:0] o_out_dst_col,
    input logic [buh_pkg::FIELD_W-1:0] o_out_dst_row,
    input logic [buh_pkg::COUNT_W-1:0] o_undo_count,
    input logic [buh_pkg::COUNT_W-1:0] o_redo_count
);

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_undo_count)))
        else $error("stalled result item dropped or changed");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_func == buh_pkg::FUNC_PUSH) |=>
        (o_out_valid && !o_move_valid && o_redo_count == '0 && o_undo_count != '0))
        else $error("push result wrong");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_func == buh_pkg::FUNC_CLEAR) |=>
        (o_out_valid && !o_move_valid && o_undo_count == '0 && o_redo_count == '0))
        else $error("clear result wrong");

    a_undo_redo_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_func == buh_pkg::FUNC_UNDO) |=> (!o_move_valid || o_redo_count != '0))
        else $error("undo returned a move but redo stack is empty");

    a_nomove_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_func == buh_pkg::FUNC_PUSH || i_func == buh_pkg::FUNC_CLEAR)) |=>
        (o_out_src_col == '0 && o_out_dst_row == '0))
        else $error("move fields not zero without a returned move");

endmodule

bind bounded_undo_redo_history_unit buh_checker u_buh_checker (.*);

@@ tb/sv/bounded_undo_redo_history_unit_tb.sv @@
// Self-checking testbench for the bounded undo/redo history unit.
`timescale 1ns / 1ps

module bounded_undo_redo_history_unit_tb;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 9;
    localparam int UNDO_SIDE = 0;
    localparam int REDO_SIDE = 1;
    localparam int LONG_HOLD = 150;
    localparam int DRAIN_SETTLE = 2;

    typedef struct packed {
        logic [buh_pkg::FIELD_W-1:0] src_col;
        logic [buh_pkg::FIELD_W-1:0] src_row;
        logic [buh_pkg::FIELD_W-1:0] dst_col;
        logic [buh_pkg::FIELD_W-1:0] dst_row;
    } t_move;

    typedef struct packed {
        logic                        move_valid;
        t_move                       mv;
        logic [buh_pkg::COUNT_W-1:0] undo_count;
        logic [buh_pkg::COUNT_W-1:0] redo_count;
    } t_outcome;

    // DUT ports
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [buh_pkg::LIMIT_W-1:0] i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [buh_pkg::FUNC_W-1:0]  i_func;
    logic [buh_pkg::FIELD_W-1:0] i_src_col;
    logic [buh_pkg::FIELD_W-1:0] i_src_row;
    logic [buh_pkg::FIELD_W-1:0] i_dst_col;
    logic [buh_pkg::FIELD_W-1:0] i_dst_row;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_move_valid;
    logic [buh_pkg::FIELD_W-1:0] o_out_src_col;
    logic [buh_pkg::FIELD_W-1:0] o_out_src_row;
    logic [buh_pkg::FIELD_W-1:0] o_out_dst_col;
    logic [buh_pkg::FIELD_W-1:0] o_out_dst_row;
    logic [buh_pkg::COUNT_W-1:0] o_undo_count;
    logic [buh_pkg::COUNT_W-1:0] o_redo_count;

    // Snapshots taken at the falling edge; they hold the values that the
    // next rising edge sees, so handshakes are decided without races.
    logic     rst_s;
    logic     in_ready_s;
    logic     out_valid_s;
    logic     out_ready_s;
    t_outcome seen_result;

    // Predictor state: one ring per stack, as the history would keep it.
    t_move hist_mem [2][buh_pkg::DEPTH_DEF];
    int    hist_top [2];
    int    hist_fill [2];
    int    limit_reg;

    t_outcome    expected_results [$];
    t_outcome    oldest_expected;
    int unsigned errors;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned cfg_writes;

    // Receiver control: random short stalls, one long hold on request.
    bit          no_idle;
    int unsigned hold_reqs;
    int unsigned hold_done;
    int          hold_left;
    int          stall_left;

    bounded_undo_redo_history_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_src_col     (i_src_col),
        .i_src_row     (i_src_row),
        .i_dst_col     (i_dst_col),
        .i_dst_row     (i_dst_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_move_valid  (o_move_valid),
        .o_out_src_col (o_out_src_col),
        .o_out_src_row (o_out_src_row),
        .o_out_dst_col (o_out_dst_col),
        .o_out_dst_row (o_out_dst_row),
        .o_undo_count  (o_undo_count),
        .o_redo_count  (o_redo_count)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rst_s                  = i_rst_n;
        in_ready_s             = o_in_ready;
        out_valid_s            = o_out_valid;
        out_ready_s            = i_out_ready;
        seen_result.move_valid = o_move_valid;
        seen_result.mv.src_col = o_out_src_col;
        seen_result.mv.src_row = o_out_src_row;
        seen_result.mv.dst_col = o_out_dst_col;
        seen_result.mv.dst_row = o_out_dst_row;
        seen_result.undo_count = o_undo_count;
        seen_result.redo_count = o_redo_count;
    end

    // ---------------------------------------------------------------- predictor

    // Zero and anything past the built depth mean the full depth.
    function automatic int eff_limit();
        if (limit_reg == 0 || limit_reg > buh_pkg::DEPTH_DEF)
            return buh_pkg::DEPTH_DEF;
        return limit_reg;
    endfunction

    // Store at the top slot and advance; the fill saturates at the limit,
    // which drops the oldest entry.
    function automatic void stack_push(int side, t_move mv);
        hist_mem[side][hist_top[side]] = mv;
        hist_top[side] = (hist_top[side] + 1) % buh_pkg::DEPTH_DEF;
        if (hist_fill[side] < eff_limit())
            hist_fill[side]++;
    endfunction

    function automatic t_move stack_pop(int side);
        hist_top[side] = (hist_top[side] + buh_pkg::DEPTH_DEF - 1) % buh_pkg::DEPTH_DEF;
        hist_fill[side]--;
        return hist_mem[side][hist_top[side]];
    endfunction

    function automatic void empty_stack(int side);
        hist_fill[side] = 0;
        hist_top[side] = 0;
    endfunction

    function automatic t_outcome predict_history(logic [buh_pkg::FUNC_W-1:0] func,
                                                 t_move mv);
        t_outcome res;
        t_move    got;
        res = '0;
        case (func)
            buh_pkg::FUNC_PUSH: begin
                stack_push(UNDO_SIDE, mv);
                empty_stack(REDO_SIDE);
            end
            buh_pkg::FUNC_UNDO: begin
                if (hist_fill[UNDO_SIDE] != 0) begin
                    got = stack_pop(UNDO_SIDE);
                    stack_push(REDO_SIDE, got);
                    res.move_valid = 1'b1;
                    res.mv.src_col = got.dst_col;
                    res.mv.src_row = got.dst_row;
                    res.mv.dst_col = got.src_col;
                    res.mv.dst_row = got.src_row;
                end
            end
            buh_pkg::FUNC_REDO: begin
                if (hist_fill[REDO_SIDE] != 0) begin
                    got = stack_pop(REDO_SIDE);
                    stack_push(UNDO_SIDE, got);
                    res.move_valid = 1'b1;
                    res.mv = got;
                end
            end
            default: begin
                empty_stack(UNDO_SIDE);
                empty_stack(REDO_SIDE);
            end
        endcase
        res.undo_count = buh_pkg::COUNT_W'(hist_fill[UNDO_SIDE]);
        res.redo_count = buh_pkg::COUNT_W'(hist_fill[REDO_SIDE]);
        return res;
    endfunction

    // ------------------------------------------------------------ result check

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t ns: %s mismatch on result item %0d, expected %0d, actual %0d",
                     $time, name, results_seen, exp_val, act_val);
        end
    endtask

    // Compare each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin
        if (rst_s && out_valid_s && out_ready_s) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t ns: result item with no expectation, expected none, actual %h",
                         $time, seen_result);
            end else begin
                oldest_expected = expected_results.pop_front();
                check_field("move_valid", oldest_expected.move_valid, seen_result.move_valid);
                check_field("src_col", oldest_expected.mv.src_col, seen_result.mv.src_col);
                check_field("src_row", oldest_expected.mv.src_row, seen_result.mv.src_row);
                check_field("dst_col", oldest_expected.mv.dst_col, seen_result.mv.dst_col);
                check_field("dst_row", oldest_expected.mv.dst_row, seen_result.mv.dst_row);
                check_field("undo_count", oldest_expected.undo_count, seen_result.undo_count);
                check_field("redo_count", oldest_expected.redo_count, seen_result.redo_count);
                results_seen++;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Stall in random bursts; on request, hold off for a long
    // stretch so the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (hold_done != hold_reqs) begin
            hold_done   <= hold_reqs;
            hold_left   <= LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 6) == 0) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------ sender

    // Favor the edge values so both extremes show up often.
    function automatic logic [buh_pkg::FIELD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return buh_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    function automatic t_move random_move();
        t_move m;
        m.src_col = random_coord();
        m.src_row = random_coord();
        m.dst_col = random_coord();
        m.dst_row = random_coord();
        return m;
    endfunction

    // Offer one item, optionally after a short gap, and hold it until the
    // block takes it; enter and leave on a rising edge.
    task automatic send_item(input logic [buh_pkg::FUNC_W-1:0] func, input t_move mv);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_src_col  <= mv.src_col;
        i_src_row  <= mv.src_row;
        i_dst_col  <= mv.dst_col;
        i_dst_row  <= mv.dst_row;
        do @(posedge i_clk); while (!in_ready_s);
        expected_results.push_back(predict_history(func, mv));
        items_sent++;
    endtask

    task automatic send_burst(input logic [buh_pkg::FUNC_W-1:0] func, input int count);
        repeat (count) send_item(func, random_move());
    endtask

    // Drop valid and wait until every expected result item has come.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Write the limit only while idle; the predictor trims both counts.
    task automatic write_limit(input logic [buh_pkg::LIMIT_W-1:0] value);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_reg = value;
        if (hist_fill[UNDO_SIDE] > eff_limit()) hist_fill[UNDO_SIDE] = eff_limit();
        if (hist_fill[REDO_SIDE] > eff_limit()) hist_fill[REDO_SIDE] = eff_limit();
        cfg_writes++;
    endtask

    function automatic logic [buh_pkg::LIMIT_W-1:0] random_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return buh_pkg::LIMIT_W'(1);
            2:       return buh_pkg::LIMIT_W'(buh_pkg::DEPTH_DEF);
            3:       return '1;
            default: return buh_pkg::LIMIT_W'($urandom_range(0, 127));
        endcase
    endfunction

    // -------------------------------------------------------------- test tasks

    // Empty stacks, extreme moves, every operation, redo dropped by a push.
    task automatic test_basic_ops();
        send_item(buh_pkg::FUNC_UNDO, random_move());
        send_item(buh_pkg::FUNC_REDO, random_move());
        send_item(buh_pkg::FUNC_PUSH, '1);
        send_item(buh_pkg::FUNC_PUSH, '0);
        send_item(buh_pkg::FUNC_PUSH, {8'h01, 8'h80, 8'h55, 8'hAA});
        send_item(buh_pkg::FUNC_UNDO, random_move());
        send_item(buh_pkg::FUNC_UNDO, random_move());
        send_item(buh_pkg::FUNC_REDO, random_move());
        send_item(buh_pkg::FUNC_PUSH, {8'hFE, 8'h7F, 8'h00, 8'hFF});
        send_item(buh_pkg::FUNC_REDO, random_move());
        send_item(buh_pkg::FUNC_CLEAR, random_move());
        send_item(buh_pkg::FUNC_UNDO, random_move());
    endtask

    // A limit of one keeps only the newest move on each stack.
    task automatic test_limit_one();
        write_limit(buh_pkg::LIMIT_W'(1));
        send_burst(buh_pkg::FUNC_PUSH, 2);
        send_burst(buh_pkg::FUNC_UNDO, 2);
        send_burst(buh_pkg::FUNC_REDO, 2);
    endtask

    // Lowering the limit trims a filled stack to its newest entries.
    task automatic test_limit_trim();
        write_limit('0);
        send_burst(buh_pkg::FUNC_PUSH, 5);
        send_item(buh_pkg::FUNC_UNDO, random_move());
        write_limit(buh_pkg::LIMIT_W'(2));
        send_burst(buh_pkg::FUNC_UNDO, 2);
        send_burst(buh_pkg::FUNC_REDO, 2);
    endtask

    // Fill past the full depth so the ring wraps, then walk it back and forth.
    task automatic test_full_depth();
        write_limit('1);
        send_burst(buh_pkg::FUNC_PUSH, buh_pkg::DEPTH_DEF + 4);
        send_burst(buh_pkg::FUNC_UNDO, buh_pkg::DEPTH_DEF + 2);
        write_limit(buh_pkg::LIMIT_W'(buh_pkg::DEPTH_DEF + 1));
        send_burst(buh_pkg::FUNC_REDO, buh_pkg::DEPTH_DEF + 2);
    endtask

    // Phases under random limits; runs of pushes, undos and redos go deep,
    // with occasional clears and single random operations as noise.
    task automatic test_random_history(input int phases, input int per_phase);
        int sent;
        int run;
        for (int p = 0; p < phases; p++) begin
            write_limit(random_limit());
            sent = 0;
            while (sent < per_phase) begin
                run = $urandom_range(1, 12);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: send_burst(buh_pkg::FUNC_PUSH, run);
                    4, 5:       send_burst(buh_pkg::FUNC_UNDO, run);
                    6, 7:       send_burst(buh_pkg::FUNC_REDO, run);
                    8: begin
                        send_item(buh_pkg::FUNC_CLEAR, random_move());
                        run = 1;
                    end
                    default: begin
                        send_item(buh_pkg::FUNC_W'($urandom_range(0, 3)), random_move());
                        run = 1;
                    end
                endcase
                sent += run;
            end
        end
    endtask

    // Hold the receiver off while items keep coming, then pause the sender
    // until every result item is back.
    task automatic test_backpressure();
        wait_drain();
        @(negedge i_clk);
        hold_reqs++;
        @(posedge i_clk);
        send_burst(buh_pkg::FUNC_PUSH, 20);
        send_burst(buh_pkg::FUNC_UNDO, 10);
        wait_drain();
        send_burst(buh_pkg::FUNC_REDO, 10);
    endtask

    // Last stretch with neither side idling.
    task automatic test_no_idle();
        wait_drain();
        no_idle = 1'b1;
        test_random_history(1, 100);
    endtask

    // -------------------------------------------------------------------- main

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_func      <= buh_pkg::FUNC_PUSH;
        i_src_col   <= '0;
        i_src_row   <= '0;
        i_dst_col   <= '0;
        i_dst_row   <= '0;
        i_out_ready <= 1'b1;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        cfg_writes   = 0;
        no_idle      = 1'b0;
        hold_reqs    = 0;
        hold_done    = 0;
        hold_left    = 0;
        stall_left   = 0;
        limit_reg    = 0;
        empty_stack(UNDO_SIDE);
        empty_stack(REDO_SIDE);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_limit_one();
        test_limit_trim();
        test_full_depth();
        test_random_history(8, 70);
        test_backpressure();
        test_no_idle();

        wait_drain();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d items of all four operations and %0d result items",
                 items_sent, results_seen);
        $display("over %0d limit writes, with random stalls, a long hold and a drain pause",
                 cfg_writes);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Generous bound on the whole run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d result items still expected", expected_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
